FILE: design/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Opcodes, fixed-point constants and the accumulator type of the
// quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

   // Operation codes
   localparam logic [2:0] OP_PRODUCT  = 3'd0;
   localparam logic [2:0] OP_ROTATE   = 3'd1;
   localparam logic [2:0] OP_COLUMN   = 3'd2;
   localparam logic [2:0] OP_ANGERR   = 3'd3;
   localparam logic [2:0] OP_VELOCITY = 3'd4;
   localparam logic [2:0] OP_COMPARE  = 3'd5;

   localparam int CSR_BITS   = 17;
   localparam logic [CSR_BITS-1:0] CSR_RESET = 17'd65535;

   // Accumulators are 64-bit sums
   localparam int ACC_BITS = 64;

   typedef logic [ACC_BITS-1:0] acc_type;

   // Rounding shift select per operation
   localparam logic [1:0] SH_F   = 2'd0;   // scale 1
   localparam logic [1:0] SH_FM1 = 2'd1;   // scale 2
   localparam logic [1:0] SH_FP1 = 2'd2;   // scale 1/2
   localparam logic [1:0] SH_2F  = 2'd3;   // rotation, second-order

endpackage

FILE: design/qau_mul_stage.sv
// ----------------------------------------------------------------------------
// qau_mul_stage
// First product stage: all pairwise products of A and B that any
// operation needs, each one registered.
// ----------------------------------------------------------------------------
module qau_mul_stage import qau_pkg::*; #(
   parameter int WORD_BITS = 20
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [WORD_BITS-1:0] a [4],
   input  logic signed [WORD_BITS-1:0] b [4],
   output acc_type                     aa_ff [4][4],
   output acc_type                     ab_ff [4][4]
);

   // Word-by-word signed product, sign-extended to accumulator width
   function automatic acc_type mul_w(input logic signed [WORD_BITS-1:0] p,
                                     input logic signed [WORD_BITS-1:0] q);
      logic signed [2*WORD_BITS-1:0] r;
      r = p * q;
      return acc_type'(r);
   endfunction

   // Products a_i*a_j and a_i*b_j
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               aa_ff[i][j] <= mul_w(a[i], a[j]);
               ab_ff[i][j] <= mul_w(a[i], b[j]);
            end
         end
      end
   end

endmodule

FILE: design/qau_sat.sv
// ----------------------------------------------------------------------------
// qau_sat
// Output stage: round half up by the operation's shift, saturate to the
// signed word range and flag overflow.
// ----------------------------------------------------------------------------
module qau_sat import qau_pkg::*; #(
   parameter int WORD_BITS = 20,
   parameter int FRAC_BITS = 16
) (
   input  acc_type                     acc,
   input  logic [1:0]                  shift_sel,
   output logic signed [WORD_BITS-1:0] res,
   output logic                        ovf
);

   localparam logic signed [ACC_BITS-1:0] LIM_HI = (ACC_BITS'(1) <<< (WORD_BITS-1)) - 1;
   localparam logic signed [ACC_BITS-1:0] LIM_LO = -(ACC_BITS'(1) <<< (WORD_BITS-1));

   logic [6:0]                  sh;
   logic signed [ACC_BITS-1:0]  rounded;

   // Select shift, add half an LSB, arithmetic shift
   always_comb begin
      case (shift_sel)
         SH_F:    sh = 7'(FRAC_BITS);
         SH_FM1:  sh = 7'(FRAC_BITS - 1);
         SH_FP1:  sh = 7'(FRAC_BITS + 1);
         SH_2F:   sh = 7'(2 * FRAC_BITS);
         default: sh = 7'(FRAC_BITS);
      endcase
      rounded = $signed(acc + (ACC_BITS'(1) << (sh - 7'd1))) >>> sh;
      ovf = 1'b0;
      if (rounded > LIM_HI) begin
         res = WORD_BITS'(LIM_HI);
         ovf = 1'b1;
      end else if (rounded < LIM_LO) begin
         res = WORD_BITS'(LIM_LO);
         ovf = 1'b1;
      end else begin
         res = WORD_BITS'(rounded);
      end
   end

endmodule

FILE: design/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit: a four-stage pipeline (operand capture and
// products, sums, rotation second-order products, round/saturate) that
// accepts one transaction every cycle unless stalled; rsp_valid for a
// transaction is v4_ff, reached through v1_ff to v3_ff. The whole pipeline
// advances together whenever the output register is empty or being
// drained, so throughput is one per clock while the consumer keeps up; a
// stalled result freezes every stage and drops req_ready in the same
// cycle. csr_ should only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Hamilton product, vector rotation, matrix column, angular error,
// derivative and same-rotation compare in signed fixed point.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_opcode,
   input  logic signed [WORD_BITS-1:0] req_a_w,
   input  logic signed [WORD_BITS-1:0] req_a_x,
   input  logic signed [WORD_BITS-1:0] req_a_y,
   input  logic signed [WORD_BITS-1:0] req_a_z,
   input  logic signed [WORD_BITS-1:0] req_b_w,
   input  logic signed [WORD_BITS-1:0] req_b_x,
   input  logic signed [WORD_BITS-1:0] req_b_y,
   input  logic signed [WORD_BITS-1:0] req_b_z,
   input  logic [1:0]                  req_column_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_out_w,
   output logic signed [WORD_BITS-1:0] rsp_out_x,
   output logic signed [WORD_BITS-1:0] rsp_out_y,
   output logic signed [WORD_BITS-1:0] rsp_out_z,
   output logic                        rsp_same_rotation,
   output logic                        rsp_overflow,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_BITS-1:0]         csr_data
);

   localparam acc_type ONE2 = acc_type'(1) << (2 * FRAC_BITS - 1);
   // Second-order sums (s, d, cross terms) fit in two words plus two bits
   localparam int SUM_BITS  = (2 * WORD_BITS + 2 < ACC_BITS) ? 2 * WORD_BITS + 2 : ACC_BITS;
   localparam int PROD_BITS = WORD_BITS + SUM_BITS;

   logic                  adv;
   logic [CSR_BITS-1:0]   thresh_ff;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0]            op1_ff, op2_ff, op3_ff;
   logic [1:0]            col1_ff;
   logic signed [WORD_BITS-1:0] a_in [4];
   logic signed [WORD_BITS-1:0] b_in [4];
   acc_type               aa [4][4];
   acc_type               ab [4][4];
   logic signed [WORD_BITS-1:0] bv1_ff [3];
   logic signed [WORD_BITS-1:0] aw1_ff;
   logic signed [WORD_BITS-1:0] bv2_ff [3];
   logic signed [WORD_BITS-1:0] aw2_ff;
   acc_type               t_in [4];
   acc_type               t_ff [4];
   acc_type               d2_ff;
   acc_type               u_in [4];
   acc_type               u_ff [4];
   logic                  same_in, same3_ff;
   logic [1:0]            sh3_ff;
   logic signed [WORD_BITS-1:0] res [4];
   logic [3:0]            ovf;
   logic signed [WORD_BITS-1:0] out_in [4];
   logic                  ovf_in;
   logic signed [WORD_BITS-1:0] out_ff [4];
   logic                  same_ff, ovf_ff;

   // Word times second-order sum, sign-extended to accumulator width
   function automatic acc_type mul_ws(input logic signed [WORD_BITS-1:0] p,
                                      input acc_type q);
      logic signed [SUM_BITS-1:0]  qn;
      logic signed [PROD_BITS-1:0] r;
      qn = $signed(q[SUM_BITS-1:0]);
      r  = p * qn;
      return acc_type'(r);
   endfunction

   assign adv       = !v4_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= CSR_RESET;
      end else if (csr_valid) begin
         thresh_ff <= csr_data;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign a_in = '{req_a_w, req_a_x, req_a_y, req_a_z};
   assign b_in = '{req_b_w, req_b_x, req_b_y, req_b_z};

   // Stage 1: products
   qau_mul_stage #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock (clock),
      .enable(adv),
      .a     (a_in),
      .b     (b_in),
      .aa_ff (aa),
      .ab_ff (ab)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff  <= req_opcode;
         col1_ff <= req_column_index;
         aw1_ff  <= req_a_w;
         bv1_ff  <= '{req_b_x, req_b_y, req_b_z};
      end
   end

   // Stage 2: sums of products (index 0=w,1=x,2=y,3=z)
   always_comb begin
      for (int k = 0; k < 4; k++) t_in[k] = '0;
      case (op1_ff)
         OP_PRODUCT: begin
            t_in[0] = ab[0][0] - (ab[1][1] + ab[2][2] + ab[3][3]);
            t_in[1] = ab[0][1] + ab[1][0] + ab[2][3] - ab[3][2];
            t_in[2] = ab[0][2] + ab[2][0] + ab[3][1] - ab[1][3];
            t_in[3] = ab[0][3] + ab[3][0] + ab[1][2] - ab[2][1];
         end
         OP_ROTATE: begin
            // s, then cross product terms; d is registered separately
            t_in[0] = aa[0][0] - (aa[1][1] + aa[2][2] + aa[3][3]);
            t_in[1] = ab[2][3] - ab[3][2];
            t_in[2] = ab[3][1] - ab[1][3];
            t_in[3] = ab[1][2] - ab[2][1];
         end
         OP_COLUMN: begin
            case (col1_ff)
               2'd0: begin
                  t_in[1] = ONE2 - (aa[2][2] + aa[3][3]);
                  t_in[2] = aa[1][2] + aa[0][3];
                  t_in[3] = aa[1][3] - aa[0][2];
               end
               2'd1: begin
                  t_in[1] = aa[1][2] - aa[0][3];
                  t_in[2] = ONE2 - (aa[1][1] + aa[3][3]);
                  t_in[3] = aa[2][3] + aa[0][1];
               end
               default: begin
                  t_in[1] = aa[1][3] + aa[0][2];
                  t_in[2] = aa[2][3] - aa[0][1];
                  t_in[3] = ONE2 - (aa[1][1] + aa[2][2]);
               end
            endcase
         end
         OP_ANGERR: begin
            t_in[1] = '0 - (ab[0][1] - ab[1][0] - ab[3][2] + ab[2][3]);
            t_in[2] = '0 - (ab[3][1] - ab[2][0] + ab[0][2] - ab[1][3]);
            t_in[3] = '0 - (ab[1][2] - ab[3][0] - ab[2][1] + ab[0][3]);
         end
         OP_VELOCITY: begin
            t_in[0] = '0 - (ab[1][1] + ab[2][2] + ab[3][3]);
            t_in[1] = ab[0][1] + ab[3][2] - ab[2][3];
            t_in[2] = ab[0][2] + ab[1][3] - ab[3][1];
            t_in[3] = ab[2][1] - ab[1][2] + ab[0][3];
         end
         OP_COMPARE: begin
            t_in[0] = ab[0][0] + ab[1][1] + ab[2][2] + ab[3][3];
         end
         default: ;
      endcase
   end

   // Rotation needs a.v as well
   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff   <= t_in;
         d2_ff  <= ab[1][1] + ab[2][2] + ab[3][3];
         op2_ff <= op1_ff;
         aw2_ff <= aw1_ff;
         bv2_ff <= bv1_ff;
      end
   end

   // Stage 3: second-order rotation terms, compare, shift selection
   // a components recovered via a dedicated register path
   logic signed [WORD_BITS-1:0] a1v_ff [3];
   logic signed [WORD_BITS-1:0] a2v_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         a1v_ff <= '{req_a_x, req_a_y, req_a_z};
         a2v_ff <= a1v_ff;
      end
   end

   always_comb begin
      u_in = t_ff;
      same_in = 1'b0;
      case (op2_ff)
         OP_ROTATE: begin
            for (int i = 0; i < 3; i++) begin
               u_in[i+1] = mul_ws(bv2_ff[i], t_ff[0])
                         + (mul_ws(aw2_ff, t_ff[i+1]) << 1)
                         + (mul_ws(a2v_ff[i], d2_ff) << 1);
            end
            u_in[0] = '0;
         end
         OP_COMPARE: begin
            same_in = ($signed(t_ff[0]) > $signed(ACC_BITS'(thresh_ff) << FRAC_BITS)) ||
                      ($signed(t_ff[0]) < -$signed(ACC_BITS'(thresh_ff) << FRAC_BITS));
            u_in[0] = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff     <= u_in;
         same3_ff <= same_in;
         op3_ff   <= op2_ff;
         case (op2_ff)
            OP_ROTATE:   sh3_ff <= SH_2F;
            OP_COLUMN:   sh3_ff <= SH_FM1;
            OP_ANGERR:   sh3_ff <= SH_FM1;
            OP_VELOCITY: sh3_ff <= SH_FP1;
            default:     sh3_ff <= SH_F;
         endcase
      end
   end

   // Stage 4: round, saturate
   for (genvar g = 0; g < 4; g++) begin : g_sat
      qau_sat #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_sat (
         .acc      (u_ff[g]),
         .shift_sel(sh3_ff),
         .res      (res[g]),
         .ovf      (ovf[g])
      );
   end

   // Mask the components each operation does not produce
   always_comb begin
      out_in = res;
      ovf_in = |ovf;
      case (op3_ff)
         OP_PRODUCT, OP_VELOCITY: begin
            ovf_in = |ovf;
         end
         OP_ROTATE, OP_COLUMN, OP_ANGERR: begin
            out_in[0] = '0;
            ovf_in    = |ovf[3:1];
         end
         default: begin
            out_in = '{default: '0};
            ovf_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff  <= out_in;
         same_ff <= same3_ff;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid         = v4_ff;
   assign rsp_out_w         = out_ff[0];
   assign rsp_out_x         = out_ff[1];
   assign rsp_out_y         = out_ff[2];
   assign rsp_out_z         = out_ff[3];
   assign rsp_same_rotation = same_ff;
   assign rsp_overflow      = ovf_ff;

endmodule

FILE: design/qau_checker.sv
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
module qau_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_same_rotation,
   input logic rsp_overflow
);

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // No response out of reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");

   // Ready whenever the output is free
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Results that flag same rotation never flag overflow
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_same_rotation |-> !rsp_overflow)
      else $error("compare with overflow");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_same_rotation(rsp_same_rotation), .rsp_overflow(rsp_overflow)
);
